>>> rtl/core/wbpm_pkg.sv
// ----------------------------------------------------------------------------
// wbpm_pkg
// Shared constants for the windowed busy percent monitor: field widths,
// command codes, configuration indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package wbpm_pkg;

    // default sizing of the record ring and the time base
    localparam int DEF_DEPTH     = 32;
    localparam int DEF_TIME_BITS = 48;

    // accumulator width, sums wrap modulo 2^64
    localparam int SUM_W = 64;

    // item fields
    localparam int CMD_W = 2;
    localparam int PCT_W = 7;

    localparam logic [CMD_W-1:0] CMD_SLEEP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WAKE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // configuration registers
    localparam int ME_W       = 6;
    localparam int WIN_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW  = 1'd1;

    localparam logic [ME_W-1:0]  ME_RESET  = 6'd32;
    localparam logic [WIN_W-1:0] WIN_RESET = 32'd2000000;

    // percent scale
    localparam int PCT_SCALE = 100;

endpackage

`default_nettype wire

>>> rtl/core/windowed_busy_percent_monitor.sv
// ----------------------------------------------------------------------------
// windowed_busy_percent_monitor
// Sliding window duty cycle meter: sleep and wake items record run and sleep
// intervals into a ring; a query item sums the ring, trims it to the window
// and entry limit, and returns run time as a percent of the total.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   command, now_usec
//   out      output     out_valid / out_stall load_percent
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// Sleep and wake items pass through a capture step and a ring update step.
// A query passes through capture, a sum over the N stored records, the open
// interval, a trim of D records (a read and a subtract each), the divider
// start, W = 64 divider steps and the result; a zero total skips the divider
// steps. The single RAM read port walks the ring, and the divider produces
// one quotient bit per cycle.
// in_stall is high from acceptance until the item is finished; a result held
// by out_stall does not block acceptance of the next item.
// Reset clears the ring count and both timestamps and restores the configuration to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_busy_percent_monitor #(
    parameter int DEPTH     = wbpm_pkg::DEF_DEPTH,
    parameter int TIME_BITS = wbpm_pkg::DEF_TIME_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [wbpm_pkg::CMD_W-1:0]      command,
    input  logic [TIME_BITS-1:0]            now_usec,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [wbpm_pkg::PCT_W-1:0]      load_percent,
    input  logic                            cfg_we,
    input  logic [wbpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbpm_pkg::CFG_DATA_W-1:0] cfg_data
);

    import wbpm_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > ME_W) ? CNT_W : ME_W;
    localparam int RW    = TIME_BITS + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_SUM      = 4'd2;
    localparam logic [3:0] S_OPEN     = 4'd3;
    localparam logic [3:0] S_TRIM     = 4'd4;
    localparam logic [3:0] S_TRIM_SUB = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    function automatic logic [AW-1:0] wrap_add(input logic [AW:0] a, input logic [AW:0] b);
        logic [AW+1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+2)'(DEPTH))
        begin
            s = s - (AW+2)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [ME_W-1:0]      max_entries_reg, max_entries_next;
    logic [WIN_W-1:0]     max_window_reg, max_window_next;
    logic [AW-1:0]        oldest_reg, oldest_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 sleeping_reg, sleeping_next;
    logic [TIME_BITS-1:0] last_sleep_reg, last_sleep_next;
    logic [TIME_BITS-1:0] last_wake_reg, last_wake_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 out_valid_reg, out_valid_next;

    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [SUM_W-1:0]     run_reg, run_next;
    logic [SUM_W-1:0]     slp_reg, slp_next;
    logic [PCT_W-1:0]     pct_reg, pct_next;
    logic [PCT_W-1:0]     load_percent_reg, load_percent_next;

    logic [CNT_W-1:0]     lim;
    logic [SUM_W-1:0]     total;
    logic                 trim_go;
    logic [SUM_W-1:0]     run_x100;
    logic [SUM_W-1:0]     rec_val;
    logic                 rec_sleep;

    logic                 push_full;
    logic [AW-1:0]        push_o1;
    logic [CNT_W-1:0]     push_c1;
    logic [CNT_W-1:0]     push_c2;
    logic [AW-1:0]        push_slot;
    logic [TIME_BITS-1:0] push_diff;

    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [RW-1:0]        ram_wdata;
    logic [RW-1:0]        ram_rdata;

    logic                 div_start;
    logic                 div_done;
    logic [SUM_W-1:0]     div_quo;

    // interval ring: time in the low bits, sleep flag on top
    wbpm_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (push_slot),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // divider for the percent
    wbpm_div #(
        .W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (run_x100),
        .divisor  (total),
        .done     (div_done),
        .quotient (div_quo)
    );

    // entry limit clipped to the ring depth
    assign lim = (CMP_W'(max_entries_reg) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                           : CNT_W'(max_entries_reg);

    // running totals and trim condition
    assign total    = run_reg + slp_reg;
    assign trim_go  = (count_reg != '0) &&
                      ((total > SUM_W'(max_window_reg)) || (count_reg > lim));
    assign run_x100 = (run_reg << 6) + (run_reg << 5) + (run_reg << 2);

    assign rec_val   = SUM_W'(ram_rdata[TIME_BITS-1:0]);
    assign rec_sleep = ram_rdata[TIME_BITS];

    // ring update for an event: drop when full, write, drop over the limit
    assign push_full = (count_reg == CNT_W'(DEPTH));
    assign push_o1   = push_full ? wrap_add((AW+1)'(oldest_reg), (AW+1)'(1)) : oldest_reg;
    assign push_c1   = push_full ? count_reg - CNT_W'(1) : count_reg;
    assign push_slot = wrap_add((AW+1)'(push_o1), (AW+1)'(push_c1));
    assign push_c2   = push_c1 + CNT_W'(1);
    assign push_diff = (cmd_reg == CMD_WAKE) ? now_reg - last_sleep_reg
                                             : now_reg - last_wake_reg;
    assign ram_wdata = {(cmd_reg == CMD_WAKE), push_diff};

    // ring read address: walk from the oldest during the sum
    assign ram_raddr = (state_reg == S_SUM) ? wrap_add((AW+1)'(oldest_reg), (AW+1)'(idx_reg))
                                            : oldest_reg;

    // configuration writes
    always_comb
    begin
        max_entries_next = max_entries_reg;
        max_window_next  = max_window_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_ENTRIES: max_entries_next = cfg_data[ME_W-1:0];
                CFG_MAX_WINDOW:  max_window_next  = cfg_data[WIN_W-1:0];
                default:         max_entries_next = max_entries_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        oldest_next       = oldest_reg;
        count_next        = count_reg;
        sleeping_next     = sleeping_reg;
        last_sleep_next   = last_sleep_reg;
        last_wake_next    = last_wake_reg;
        idx_next          = idx_reg;
        rd_pend_next      = 1'b0;
        out_valid_next    = out_valid_reg;
        cmd_next          = cmd_reg;
        now_next          = now_reg;
        run_next          = run_reg;
        slp_next          = slp_reg;
        pct_next          = pct_reg;
        load_percent_next = load_percent_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        div_start         = 1'b0;

        // result taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    now_next   = now_usec;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (cmd_reg)
                    CMD_SLEEP, CMD_WAKE:
                    begin
                        ram_we = 1'b1;
                        if (push_c2 > lim)
                        begin
                            oldest_next = wrap_add((AW+1)'(push_o1), (AW+1)'(1));
                            count_next  = push_c1;
                        end
                        else
                        begin
                            oldest_next = push_o1;
                            count_next  = push_c2;
                        end
                        if (cmd_reg == CMD_SLEEP)
                        begin
                            sleeping_next   = 1'b1;
                            last_sleep_next = now_reg;
                        end
                        else
                        begin
                            sleeping_next  = 1'b0;
                            last_wake_next = now_reg;
                        end
                    end
                    CMD_QUERY:
                    begin
                        run_next   = '0;
                        slp_next   = '0;
                        idx_next   = '0;
                        state_next = S_SUM;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SUM:
            begin
                // issue one read per cycle, accumulate the data in the following cycle
                if (idx_reg < count_reg)
                begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + CNT_W'(1);
                end
                else if (!rd_pend_reg)
                begin
                    state_next = S_OPEN;
                end
                if (rd_pend_reg)
                begin
                    if (rec_sleep)
                    begin
                        slp_next = slp_reg + rec_val;
                    end
                    else
                    begin
                        run_next = run_reg + rec_val;
                    end
                end
            end
            S_OPEN:
            begin
                // open interval since the last transition
                if (sleeping_reg)
                begin
                    slp_next = slp_reg + SUM_W'(TIME_BITS'(now_reg - last_sleep_reg));
                end
                else
                begin
                    run_next = run_reg + SUM_W'(TIME_BITS'(now_reg - last_wake_reg));
                end
                state_next = S_TRIM;
            end
            S_TRIM:
            begin
                if (trim_go)
                begin
                    ram_re     = 1'b1;
                    state_next = S_TRIM_SUB;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_TRIM_SUB:
            begin
                if (rec_sleep)
                begin
                    slp_next = slp_reg - rec_val;
                end
                else
                begin
                    run_next = run_reg - rec_val;
                end
                oldest_next = wrap_add((AW+1)'(oldest_reg), (AW+1)'(1));
                count_next  = count_reg - CNT_W'(1);
                state_next  = S_TRIM;
            end
            S_MUL:
            begin
                if (total == '0)
                begin
                    pct_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pct_next   = (div_quo > SUM_W'(PCT_SCALE)) ? PCT_W'(PCT_SCALE)
                                                               : div_quo[PCT_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    load_percent_next = pct_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_entries_reg <= ME_RESET;
            max_window_reg  <= WIN_RESET;
            oldest_reg      <= '0;
            count_reg       <= '0;
            sleeping_reg    <= 1'b0;
            last_sleep_reg  <= '0;
            last_wake_reg   <= '0;
            idx_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_entries_reg <= max_entries_next;
            max_window_reg  <= max_window_next;
            oldest_reg      <= oldest_next;
            count_reg       <= count_next;
            sleeping_reg    <= sleeping_next;
            last_sleep_reg  <= last_sleep_next;
            last_wake_reg   <= last_wake_next;
            idx_reg         <= idx_next;
            rd_pend_reg     <= rd_pend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        now_reg          <= now_next;
        run_reg          <= run_next;
        slp_reg          <= slp_next;
        pct_reg          <= pct_next;
        load_percent_reg <= load_percent_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign load_percent = load_percent_reg;

    // ring occupancy and head stay in range
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("record count beyond ring depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg < AW'(DEPTH)) || (AW'(DEPTH) == '0))
        else $error("oldest slot out of range");

    // after trimming the ring fits the window and the entry limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |->
        (count_reg == '0) || ((total <= SUM_W'(max_window_reg)) && (count_reg <= lim)))
        else $error("trim left ring over its limits");

    // a result appears only at the end of a query
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result without a finished query");

endmodule

`default_nettype wire

>>> rtl/core/wbpm_ram.sv
// ----------------------------------------------------------------------------
// wbpm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/wbpm_div.sv
// ----------------------------------------------------------------------------
// wbpm_div
// Iterative restoring divider, one quotient bit per cycle. The quotient
// holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpm_div #(
    parameter int W = wbpm_pkg::SUM_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W) + 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W:0]    shifted;
    logic          ge;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? W'(shifted - {1'b0, den_reg}) : W'(shifted);
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // a running division never sees a new start
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !start)
        else $error("divider restarted while busy");

    // done follows in the cycle after the last step
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == CW'(1)) |=> done_reg)
        else $error("divider missed done");

endmodule

`default_nettype wire
